>>> rtl/first_fit_contiguous_run_allocator_defines.svh
// assertion helpers for first_fit_contiguous_run_allocator.sv
`ifndef FIRST_FIT_CONTIGUOUS_RUN_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_CONTIGUOUS_RUN_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FFCR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ffcr assertion failed");

// next-cycle implication, checked outside reset
`define FFCR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffcr assertion failed");

`endif

>>> rtl/ffcr_pkg.sv
package ffcr_pkg;

	localparam int ROWS_A = 16;
	localparam int ROWS_B = 16;
	localparam int SEATS_PER_ROW = 16;

	localparam int ROWS_MAX = (ROWS_A > ROWS_B) ? ROWS_A : ROWS_B;
	localparam int ROW_W = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
	localparam int ROW_A_W = (ROWS_A > 1) ? $clog2(ROWS_A) : 1;
	localparam int ROW_B_W = (ROWS_B > 1) ? $clog2(ROWS_B) : 1;
	localparam int SEAT_W = (SEATS_PER_ROW > 1) ? $clog2(SEATS_PER_ROW) : 1;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_RELEASE = 1'b1;
	localparam logic ZONE_A = 1'b0;
	localparam logic ZONE_B = 1'b1;

	typedef logic [ROW_W-1:0] row_t;
	typedef logic [SEAT_W-1:0] seat_t;
	typedef logic [SEATS_PER_ROW-1:0] seats_t;
	typedef logic [3:0] row_fld_t;
	typedef logic [3:0] seat_fld_t;
	typedef logic [4:0] cnt_fld_t;

	typedef struct packed {
		logic op;
		logic zone;
		cnt_fld_t seat_count;
		row_fld_t release_row;
		seat_fld_t release_seat;
	} req_t;

	typedef struct packed {
		logic granted;
		row_fld_t granted_row;
		seat_fld_t granted_seat;
	} rsp_t;

	typedef struct packed {
		logic en;
		logic zone;
		row_t row;
		seats_t data;
	} map_wr_t;

	// n adjacent seats from seat s, clipped at the row end
	function automatic seats_t run_mask(int s, int n);
		seats_t m;
		m = '0;
		for (int i = 0; i < SEATS_PER_ROW; i++) begin
			m[i] = (i >= s) && (i < s + n);
		end
		return m;
	endfunction

endpackage

>>> rtl/first_fit_contiguous_run_allocator.sv
// channel | dir | handshake             | payload
// req     | in  | req_valid / req_stall | ffcr_pkg::req_t (op, zone, count, row, seat)
// rsp     | out | rsp_valid / rsp_stall | ffcr_pkg::rsp_t (granted, row, seat)
//
// allocate: the request is taken in S_IDLE, then one row of the chosen map per cycle goes
// through the shared run finder in S_SCAN until a row fits or the last row is reached.
// release passes through S_DONE; an allocate with a bad count ends at the first row.
// arst_n clears both occupancy maps at once; no clearing pass.
// a finished result waits in the output register while rsp_stall is high; the next
// request is taken meanwhile and holds before write back until the register frees.
module first_fit_contiguous_run_allocator (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input ffcr_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output ffcr_pkg::rsp_t rsp
);

	`include "first_fit_contiguous_run_allocator_defines.svh"

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q, state_d;
	ffcr_pkg::req_t req_q;
	ffcr_pkg::row_t row_q;
	logic row_inc;
	logic rsp_valid_q;
	ffcr_pkg::rsp_t rsp_q, rsp_d;
	logic rsp_load;

	ffcr_pkg::map_wr_t map_wr;
	ffcr_pkg::seats_t rd_data;
	logic found;
	ffcr_pkg::seat_t found_seat;
	ffcr_pkg::seats_t alloc_mask;

	logic count_ok, rel_ok, last_row, hit, slot_free;
	ffcr_pkg::seats_t rel_mask;

	ffcr_map u_map (
		.clk(clk),
		.arst_n(arst_n),
		.wr(map_wr),
		.rd_zone(req_q.zone),
		.rd_row(row_q),
		.rd_data(rd_data)
	);

	ffcr_run_find u_find (
		.row_bits(rd_data),
		.count(req_q.seat_count),
		.found(found),
		.seat(found_seat),
		.mask(alloc_mask)
	);

	assign count_ok = (req_q.seat_count != '0) &&
		(int'(req_q.seat_count) <= ffcr_pkg::SEATS_PER_ROW);
	assign rel_ok = ((req_q.zone == ffcr_pkg::ZONE_A) ?
		(int'(req_q.release_row) < ffcr_pkg::ROWS_A) :
		(int'(req_q.release_row) < ffcr_pkg::ROWS_B)) &&
		(int'(req_q.release_seat) < ffcr_pkg::SEATS_PER_ROW);
	assign rel_mask = ffcr_pkg::run_mask(int'(req_q.release_seat), int'(req_q.seat_count));
	assign last_row = (req_q.zone == ffcr_pkg::ZONE_A) ?
		(row_q == ffcr_pkg::row_t'(ffcr_pkg::ROWS_A - 1)) :
		(row_q == ffcr_pkg::row_t'(ffcr_pkg::ROWS_B - 1));
	assign hit = count_ok && found;
	assign slot_free = !rsp_valid_q || !rsp_stall;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		state_d = state_q;
		row_inc = 1'b0;
		rsp_load = 1'b0;
		rsp_d = '0;
		map_wr = '0;
		map_wr.zone = req_q.zone;
		map_wr.row = row_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = (req.op == ffcr_pkg::OP_ALLOC) ? S_SCAN : S_DONE;
				end
			end
			S_SCAN: begin
				if (hit || last_row || !count_ok) begin
					// hold the scan position until the output register is free
					if (slot_free) begin
						map_wr.en = hit;
						map_wr.data = rd_data | alloc_mask;
						rsp_load = 1'b1;
						rsp_d.granted = hit;
						rsp_d.granted_row = hit ? ffcr_pkg::row_fld_t'(row_q) : '0;
						rsp_d.granted_seat = hit ? ffcr_pkg::seat_fld_t'(found_seat) : '0;
						state_d = S_IDLE;
					end
				end else begin
					row_inc = 1'b1;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					map_wr.en = rel_ok;
					map_wr.data = rd_data & ~rel_mask;
					rsp_load = 1'b1;
					rsp_d.granted = rel_ok;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && req_valid) begin
				row_q <= (req.op == ffcr_pkg::OP_RELEASE) ?
					ffcr_pkg::row_t'(req.release_row) : '0;
			end else if (row_inc) begin
				row_q <= ffcr_pkg::row_t'(row_q + 1'b1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	`FFCR_ASSERT_NOW(a_wr_busy, map_wr.en, state_q != S_IDLE && rsp_load)
	`FFCR_ASSERT_NEXT(a_take_busy, req_valid && !req_stall, state_q != S_IDLE)
	`FFCR_ASSERT_NOW(a_alloc_sets_only, state_q == S_SCAN && map_wr.en,
		(map_wr.data & rd_data) == rd_data && map_wr.data != rd_data)
	`FFCR_ASSERT_NOW(a_miss_zero, rsp_valid_q && !rsp_q.granted,
		rsp_q.granted_row == '0 && rsp_q.granted_seat == '0)

endmodule

>>> rtl/ffcr_map.sv
module ffcr_map (
	input logic clk,
	input logic arst_n,
	input ffcr_pkg::map_wr_t wr,
	input logic rd_zone,
	input ffcr_pkg::row_t rd_row,
	output ffcr_pkg::seats_t rd_data
);

	ffcr_pkg::seats_t map_a_q [ffcr_pkg::ROWS_A];
	ffcr_pkg::seats_t map_b_q [ffcr_pkg::ROWS_B];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ffcr_pkg::ROWS_A; i++) begin
				map_a_q[i] <= '0;
			end
			for (int i = 0; i < ffcr_pkg::ROWS_B; i++) begin
				map_b_q[i] <= '0;
			end
		end else if (wr.en) begin
			if (wr.zone == ffcr_pkg::ZONE_A && int'(wr.row) < ffcr_pkg::ROWS_A) begin
				map_a_q[wr.row[ffcr_pkg::ROW_A_W-1:0]] <= wr.data;
			end
			if (wr.zone == ffcr_pkg::ZONE_B && int'(wr.row) < ffcr_pkg::ROWS_B) begin
				map_b_q[wr.row[ffcr_pkg::ROW_B_W-1:0]] <= wr.data;
			end
		end
	end

	always_comb begin
		rd_data = '0;
		if (rd_zone == ffcr_pkg::ZONE_A) begin
			if (int'(rd_row) < ffcr_pkg::ROWS_A) begin
				rd_data = map_a_q[rd_row[ffcr_pkg::ROW_A_W-1:0]];
			end
		end else begin
			if (int'(rd_row) < ffcr_pkg::ROWS_B) begin
				rd_data = map_b_q[rd_row[ffcr_pkg::ROW_B_W-1:0]];
			end
		end
	end

endmodule

>>> rtl/ffcr_run_find.sv
module ffcr_run_find (
	input ffcr_pkg::seats_t row_bits,
	input ffcr_pkg::cnt_fld_t count,
	output logic found,
	output ffcr_pkg::seat_t seat,
	output ffcr_pkg::seats_t mask
);

	ffcr_pkg::seats_t fit;

	// every start position is checked side by side
	always_comb begin
		for (int s = 0; s < ffcr_pkg::SEATS_PER_ROW; s++) begin
			fit[s] = (s + int'(count) <= ffcr_pkg::SEATS_PER_ROW) &&
				((row_bits & ffcr_pkg::run_mask(s, int'(count))) == '0);
		end
	end

	// lowest fitting start wins
	always_comb begin
		seat = '0;
		for (int s = ffcr_pkg::SEATS_PER_ROW - 1; s >= 0; s--) begin
			if (fit[s]) begin
				seat = ffcr_pkg::seat_t'(s);
			end
		end
	end

	assign found = |fit;
	assign mask = ffcr_pkg::run_mask(int'(seat), int'(count));

endmodule

>>> tb/ffcr_grant_checker.sv
`timescale 1ns / 100ps

module ffcr_grant_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input ffcr_pkg::req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input ffcr_pkg::rsp_t rsp,
	output int mismatches,
	output int outstanding
);
	import ffcr_pkg::*;

	seats_t seats_a [ROWS_A];
	seats_t seats_b [ROWS_B];
	rsp_t grants_due [$];
	rsp_t want;

	// run of len seats from seat first, anything past the row end dropped
	function automatic seats_t seat_run(input int first, input int len);
		logic [63:0] span;
		span = ((64'd1 << len) - 64'd1) << first;
		return span[SEATS_PER_ROW-1:0];
	endfunction

	// applies one request to the seat maps and returns the grant it earns
	function automatic rsp_t next_grant(input req_t r);
		rsp_t res;
		seats_t occ;
		seats_t run;
		int rows;
		int len;
		res = '0;
		len = int'(r.seat_count);
		rows = (r.zone == ZONE_B) ? ROWS_B : ROWS_A;
		if (r.op == OP_ALLOC) begin
			if (len >= 1 && len <= SEATS_PER_ROW) begin
				for (int row = 0; row < rows && !res.granted; row++) begin
					occ = (r.zone == ZONE_B) ? seats_b[row] : seats_a[row];
					// lowest free start in the first row that fits wins
					for (int s = 0; s + len <= SEATS_PER_ROW && !res.granted; s++) begin
						run = seat_run(s, len);
						if ((occ & run) == '0) begin
							res.granted = 1'b1;
							res.granted_row = row_fld_t'(row);
							res.granted_seat = seat_fld_t'(s);
							if (r.zone == ZONE_B)
								seats_b[row] = occ | run;
							else
								seats_a[row] = occ | run;
						end
					end
				end
			end
		end else if (int'(r.release_row) < rows && int'(r.release_seat) < SEATS_PER_ROW) begin
			run = seat_run(int'(r.release_seat), len);
			if (r.zone == ZONE_B)
				seats_b[r.release_row] = seats_b[r.release_row] & ~run;
			else
				seats_a[r.release_row] = seats_a[r.release_row] & ~run;
			res.granted = 1'b1;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (seats_a[i])
				seats_a[i] = '0;
			foreach (seats_b[i])
				seats_b[i] = '0;
			grants_due.delete();
			mismatches = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (grants_due.size() == 0) begin
					$write("%0t: grant with no request pending, expected none,", $time);
					$display(" actual granted=%0d row=%0d seat=%0d",
						rsp.granted, rsp.granted_row, rsp.granted_seat);
					mismatches++;
				end else begin
					want = grants_due.pop_front();
					if (rsp.granted !== want.granted || rsp.granted_row !== want.granted_row ||
							rsp.granted_seat !== want.granted_seat) begin
						$write("%0t: grant mismatch, expected granted=%0d row=%0d seat=%0d,",
							$time, want.granted, want.granted_row, want.granted_seat);
						$display(" actual granted=%0d row=%0d seat=%0d",
							rsp.granted, rsp.granted_row, rsp.granted_seat);
						mismatches++;
					end
				end
			end
			if (req_valid && !req_stall)
				grants_due.push_back(next_grant(req));
		end
		outstanding = grants_due.size();
	end

endmodule

>>> tb/tb_first_fit_contiguous_run_allocator.sv
`timescale 1ns / 100ps

module tb_first_fit_contiguous_run_allocator;
	import ffcr_pkg::*;

	localparam int RANDOM_REQS = 2000;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int mismatches;
	int outstanding;
	int idle_cycles = 0;
	int burst_left = 0;
	int stall_phase_left = 0;
	int stall_style = 0;
	int stall_run = 0;

	first_fit_contiguous_run_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	ffcr_grant_checker grant_check (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver switches between free flow, light, heavy and long-run stalling
	always @(posedge clk) begin
		if (stall_phase_left == 0) begin
			stall_style <= $urandom_range(0, 3);
			stall_phase_left <= $urandom_range(20, 300);
		end else begin
			stall_phase_left <= stall_phase_left - 1;
		end
		case (stall_style)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 2) == 0);
			2: rsp_stall <= ($urandom_range(0, 3) != 0);
			default: begin
				if (stall_run == 0) begin
					rsp_stall <= !rsp_stall;
					stall_run <= $urandom_range(1, 40);
				end else begin
					stall_run <= stall_run - 1;
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_first_fit_contiguous_run_allocator NOT OK");
				$finish;
			end
		end
	end

	function automatic req_t make_req(input logic op, input logic zone, input int count,
			input int row, input int seat);
		req_t r;
		r.op = op;
		r.zone = zone;
		r.seat_count = cnt_fld_t'(count);
		r.release_row = row_fld_t'(row);
		r.release_seat = seat_fld_t'(seat);
		return r;
	endfunction

	// sender runs in bursts; a gap opens whenever the current burst is used up
	task automatic issue(input req_t r);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic issue_random();
		req_t r;
		int pick;
		int count;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 6);
			r = make_req(OP_ALLOC, 1'($urandom_range(0, 1)), count, $urandom_range(0, 15),
				$urandom_range(0, 15));
		end else if (pick < 88) begin
			r = make_req(OP_RELEASE, 1'($urandom_range(0, 1)), $urandom_range(1, 8),
				$urandom_range(0, 15), $urandom_range(0, 15));
		end else if (pick < 93) begin
			// a full-row length of 16, or any length from 0 to 31 that may run past the row end
			count = ($urandom_range(0, 1) == 0) ? 16 : $urandom_range(0, 31);
			r = make_req(OP_RELEASE, 1'($urandom_range(0, 1)), count, $urandom_range(0, 15),
				$urandom_range(0, 15));
		end else begin
			r = make_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				$urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 15));
		end
		issue(r);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill zone a row by row, the last grant lands in the last row
		for (int i = 0; i < ROWS_A; i++)
			issue(make_req(OP_ALLOC, ZONE_A, 16, 0, 0));
		issue(make_req(OP_ALLOC, ZONE_A, 1, 0, 0));
		// release running past the row end clears the whole last row
		issue(make_req(OP_RELEASE, ZONE_A, 31, 15, 0));
		issue(make_req(OP_RELEASE, ZONE_A, 0, 3, 15));
		issue(make_req(OP_RELEASE, ZONE_A, 1, 3, 15));
		issue(make_req(OP_ALLOC, ZONE_A, 2, 0, 0));
		// freeing seats that are already free
		issue(make_req(OP_RELEASE, ZONE_B, 3, 0, 5));
		issue(make_req(OP_ALLOC, ZONE_B, 0, 0, 0));
		issue(make_req(OP_ALLOC, ZONE_B, 17, 0, 0));
		issue(make_req(OP_ALLOC, ZONE_B, 31, 15, 15));

		for (int n = 0; n < RANDOM_REQS; n++)
			issue_random();
		req_valid <= 1'b0;

		// let the checker book the last request before counting what is left
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("tb_first_fit_contiguous_run_allocator OK");
		else
			$display("tb_first_fit_contiguous_run_allocator NOT OK");
		$finish;
	end

endmodule

>>> first_fit_contiguous_run_allocator.f
+incdir+rtl
rtl/ffcr_pkg.sv
rtl/ffcr_map.sv
rtl/ffcr_run_find.sv
rtl/first_fit_contiguous_run_allocator.sv
tb/ffcr_grant_checker.sv
tb/tb_first_fit_contiguous_run_allocator.sv
